[sv/krl_pkg.sv]
// Shared constants and control/status types for the keyed rate limit table.
package krl_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int KEY_W = 32;
	localparam int TIME_W = 64;
	localparam int INTERVAL_W = 32;
	localparam int SLOT_INDEX_W = 4;
	localparam int ENTRY_W = KEY_W + TIME_W;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;

	typedef struct packed {
		logic start;
		logic scan_rd;
		logic fetch_rd;
		logic commit;
	} krl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic can_load;
	} krl_status_t;

endpackage

[sv/krl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module krl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/krl_datapath.sv]
// Datapath: slot table, scan trackers, interval register and result register.
module krl_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [krl_pkg::INTERVAL_W-1:0]       cfg_data,
	input  logic [krl_pkg::KEY_W-1:0]            key_id,
	input  logic [krl_pkg::TIME_W-1:0]           now_time,
	input  krl_pkg::krl_cmd_t                    cmd,
	output krl_pkg::krl_status_t                 status,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic                                 allowed,
	output logic [krl_pkg::SLOT_INDEX_W-1:0]     slot_index
);

	logic [krl_pkg::INTERVAL_W-1:0] interval_q;
	logic [krl_pkg::KEY_W-1:0]      key_q;
	logic [krl_pkg::TIME_W-1:0]     now_q;

	logic [krl_pkg::SLOT_W-1:0] cnt_q;
	logic [krl_pkg::SLOT_W-1:0] eval_idx_s1;
	logic                       scan_rd_s1;
	logic [krl_pkg::SLOT_W-1:0] match_idx_q;
	logic [krl_pkg::SLOT_W-1:0] free_idx_q;
	logic [krl_pkg::SLOT_W-1:0] oldest_idx_q;
	logic                       match_found_q;
	logic                       free_found_q;
	logic [krl_pkg::TIME_W-1:0] oldest_time_q;
	logic [krl_pkg::SLOT_W-1:0] chosen_idx;
	logic [krl_pkg::SLOT_W-1:0] raddr;

	logic [krl_pkg::SLOT_COUNT-1:0] entry_valid_q;
	logic                           rd_valid_q;
	logic                           re;
	logic                           we;
	logic [krl_pkg::ENTRY_W-1:0]    rdata;
	logic [krl_pkg::ENTRY_W-1:0]    wdata;
	logic [krl_pkg::KEY_W-1:0]      entry_key;
	logic [krl_pkg::TIME_W-1:0]     entry_time;
	logic [krl_pkg::TIME_W-1:0]     elapsed;
	logic                           allow_c;

	logic                                out_valid_q;
	logic                                allowed_q;
	logic [krl_pkg::SLOT_INDEX_W-1:0]    slot_index_q;

	// A slot never written reads as free with time zero.
	assign entry_key  = rd_valid_q ? rdata[krl_pkg::ENTRY_W-1:krl_pkg::TIME_W] : '0;
	assign entry_time = rd_valid_q ? rdata[krl_pkg::TIME_W-1:0] : '0;

	always_comb begin
		priority if (match_found_q) begin
			chosen_idx = match_idx_q;
		end else if (free_found_q) begin
			chosen_idx = free_idx_q;
		end else begin
			chosen_idx = oldest_idx_q;
		end
	end

	assign raddr   = cmd.fetch_rd ? chosen_idx : cnt_q;
	assign re      = cmd.scan_rd | cmd.fetch_rd;
	assign elapsed = now_q - entry_time;
	assign allow_c = elapsed >= {{(krl_pkg::TIME_W-krl_pkg::INTERVAL_W){1'b0}}, interval_q};
	assign we      = cmd.commit & allow_c;
	assign wdata   = {key_q, now_q};

	krl_ram #(
		.WIDTH(krl_pkg::ENTRY_W),
		.DEPTH(krl_pkg::SLOT_COUNT)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (chosen_idx),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= krl_pkg::INTERVAL_RESET;
		end else if (cfg_valid) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= key_id;
			now_q <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_valid_q    <= 1'b0;
		end else begin
			if (re) begin
				rd_valid_q <= entry_valid_q[raddr];
			end
			if (we) begin
				entry_valid_q[chosen_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			scan_rd_s1    <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			scan_rd_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				cnt_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (scan_rd_s1) begin
					if (!match_found_q && entry_key == key_q) begin
						match_found_q <= 1'b1;
					end
					if (!free_found_q && entry_key == '0) begin
						free_found_q <= 1'b1;
					end
				end
			end
		end
	end

	// Trackers: first match, first free slot, oldest time with lowest index on ties.
	always_ff @(posedge clk) begin
		eval_idx_s1 <= cnt_q;
		if (scan_rd_s1) begin
			if (!match_found_q && entry_key == key_q) begin
				match_idx_q <= eval_idx_s1;
			end
			if (!free_found_q && entry_key == '0) begin
				free_idx_q <= eval_idx_s1;
			end
			if (eval_idx_s1 == '0 || entry_time < oldest_time_q) begin
				oldest_time_q <= entry_time;
				oldest_idx_q  <= eval_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			allowed_q    <= allow_c;
			slot_index_q <= krl_pkg::SLOT_INDEX_W'(chosen_idx);
		end
	end

	assign status.scan_last = (cnt_q == krl_pkg::SLOT_W'(krl_pkg::SLOT_COUNT - 1));
	assign status.can_load  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign allowed    = allowed_q;
	assign slot_index = slot_index_q;

	a_trackers_clear: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rd_s1 && eval_idx_s1 == '0 |-> !match_found_q && !free_found_q)
		else $error("scan trackers not cleared at first slot");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled result");

	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> entry_valid_q[$past(chosen_idx)])
		else $error("written slot not marked valid");

endmodule

[sv/krl_ctrl.sv]
// Controller state machine: accept, scan the table, fetch the chosen slot, decide.
module krl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  krl_pkg::krl_status_t status,
	output krl_pkg::krl_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_FETCH  = 5'b01000,
		ST_DECIDE = 5'b10000
	} krl_state_t;

	krl_state_t state_q;
	krl_state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last scan read data is evaluated here
			ST_DRAIN: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch_rd = 1'b1;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.can_load) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && status.scan_last |=> state_q == ST_DRAIN)
		else $error("scan did not end after last slot");

	a_fetch_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch_rd |=> state_q == ST_DECIDE && !cmd.scan_rd)
		else $error("fetch not followed by decide");

	a_hold_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE && !status.can_load |=> state_q == ST_DECIDE)
		else $error("left decide while result register busy");

endmodule

[sv/keyed_rate_limit_table_top.sv]
// Top level of the keyed rate limit table: controller, datapath and config port.
// A result becomes valid after the scan reads all 16 table slots, then a drain step,
//   a fetch of the chosen slot and the decide step.
// The scan runs over the single RAM read port; a new request is accepted only in idle.
// A waiting result does not block the next input transaction; it only delays the decide step.
// Reset clears the slot valid flags at once (all slots free, time 0) and sets interval to 1000.
module keyed_rate_limit_table_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [krl_pkg::KEY_W-1:0]            key_id,
	input  logic [krl_pkg::TIME_W-1:0]           now_time,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 allowed,
	output logic [krl_pkg::SLOT_INDEX_W-1:0]     slot_index,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [krl_pkg::INTERVAL_W-1:0]       cfg_data
);

	krl_pkg::krl_cmd_t    cmd;
	krl_pkg::krl_status_t status;

	assign cfg_ready = 1'b1;

	krl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	krl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.key_id     (key_id),
		.now_time   (now_time),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.allowed    (allowed),
		.slot_index (slot_index)
	);

endmodule
